[src/shared_buffer_multi_queue_macros.svh]
// assertion macros for the shared buffer queue block
`ifndef SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBMQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SBMQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sbmq_pkg.sv]
package sbmq_pkg;

    localparam int SLOTS      = 16;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam int OPCODE_W = 1;
    localparam int QID_W    = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
        logic commit;
    } sbmq_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } link_t;

    // link of a slot that was never rewritten: slot i points to i+1, the last slot has no link
    function automatic link_t reset_link(input logic [SLOT_W-1:0] idx);
        link_t lnk;
        lnk.valid = (idx != SLOT_W'(SLOTS - 1));
        lnk.slot  = lnk.valid ? SLOT_W'(idx + SLOT_W'(1)) : '0;
        return lnk;
    endfunction

endpackage

[src/sbmq_req_if.sv]
interface sbmq_req_if
    import sbmq_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [QID_W-1:0]           queue_id;
    logic signed [WORD_W-1:0]   push_data;

    modport source (output valid, output opcode, output queue_id, output push_data,
                    input ready);
    modport sink   (input valid, input opcode, input queue_id, input push_data,
                    output ready);
endinterface

[src/sbmq_rsp_if.sv]
interface sbmq_rsp_if
    import sbmq_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [WORD_W-1:0]   pop_data;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output pop_data, output status, input ready);
    modport sink   (input valid, input pop_data, input status, output ready);
endinterface

[src/sbmq_ctrl.sv]
`include "shared_buffer_multi_queue_macros.svh"

module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output sbmq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       commit;
    logic       accept;

    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_WB) && out_free;
    assign in_ready = (state_reg == S_IDLE) || commit;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                state_next = accept ? S_EXEC : S_IDLE;
            end
            S_EXEC:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (commit)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = commit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.load   = accept;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.commit = commit;

    `SBMQ_ASSERT_NXT(a_accept_to_exec, in_valid && in_ready, state_reg == S_EXEC, "accepted item did not start")
    `SBMQ_ASSERT_NXT(a_result_held, out_valid_reg && !out_ready, out_valid_reg, "pending result dropped")
    `SBMQ_ASSERT_IMP(a_wb_after_exec, state_reg == S_WB, $past(state_reg) == S_EXEC || $past(state_reg) == S_WB, "write-back without execute")
    `SBMQ_ASSERT_NXT(a_commit_shows, commit, out_valid_reg, "committed result not shown")

endmodule

[src/sbmq_dp.sv]
module sbmq_dp
    import sbmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sbmq_cmd_t                cmd,
    input  logic [OPCODE_W-1:0]      opcode,
    input  logic [QID_W-1:0]         queue_id,
    input  logic signed [WORD_W-1:0] push_data,
    output logic signed [WORD_W-1:0] pop_data,
    output logic [STATUS_W-1:0]      status
);

    // item registers
    logic [OPCODE_W-1:0]   op_reg;
    logic [QIDX_W-1:0]     q_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [STATUS_W-1:0]   res_reg;

    // queue and free list state
    logic [SLOT_W-1:0]     head_reg [QUEUES];
    logic [SLOT_W-1:0]     tail_reg [QUEUES];
    logic [QUEUES-1:0]     nonempty_reg;
    logic [SLOT_W-1:0]     free_head_reg;
    logic                  free_ne_reg;

    // link store and data store
    link_t                 link_mem [SLOTS];
    logic [SLOTS-1:0]      link_wr_reg;
    link_t                 link_rd_reg;
    logic [DATA_WIDTH-1:0] data_mem [SLOTS];
    logic [DATA_WIDTH-1:0] data_rd_reg;

    logic [WORD_W-1:0]     pop_data_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic [SLOT_W-1:0]     exec_idx;
    logic                  exec_ok;
    logic [STATUS_W-1:0]   exec_res;
    logic                  lw_en;
    logic [SLOT_W-1:0]     lw_addr;
    link_t                 lw_data;
    logic                  done_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            q_reg    <= QIDX_W'(queue_id % QUEUES);
            word_reg <= DATA_WIDTH'($unsigned(push_data));
        end
    end

    always_comb
    begin
        if (op_reg == OP_PUSH)
        begin
            exec_idx = free_head_reg;
            exec_ok  = free_ne_reg;
            exec_res = free_ne_reg ? ST_OK : ST_OVERFLOW;
        end
        else
        begin
            exec_idx = head_reg[q_reg];
            exec_ok  = nonempty_reg[q_reg];
            exec_res = nonempty_reg[q_reg] ? ST_OK : ST_UNDERFLOW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            idx_reg <= exec_idx;
            res_reg <= exec_res;
        end
    end

    assign done_ok = cmd.commit && (res_reg == ST_OK);

    // one link write a cycle: tail append in execute, slot relink in write-back
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = idx_reg;
        lw_data = '0;
        if (cmd.exec && exec_ok && (op_reg == OP_PUSH) && nonempty_reg[q_reg])
        begin
            lw_en         = 1'b1;
            lw_addr       = tail_reg[q_reg];
            lw_data.valid = 1'b1;
            lw_data.slot  = exec_idx;
        end
        else if (done_ok)
        begin
            lw_en   = 1'b1;
            lw_addr = idx_reg;
            if (op_reg == OP_POP)
            begin
                lw_data.valid = free_ne_reg;
                lw_data.slot  = free_head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        if (cmd.exec)
        begin
            link_rd_reg <= link_wr_reg[exec_idx] ? link_mem[exec_idx] : reset_link(exec_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_wr_reg <= '0;
        end
        else if (lw_en)
        begin
            link_wr_reg[lw_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && exec_ok && (op_reg == OP_PUSH))
        begin
            data_mem[exec_idx] <= word_reg;
        end
        if (cmd.exec && (op_reg == OP_POP))
        begin
            data_rd_reg <= data_mem[exec_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            nonempty_reg  <= '0;
            free_head_reg <= '0;
            free_ne_reg   <= 1'b1;
        end
        else if (done_ok)
        begin
            if (op_reg == OP_PUSH)
            begin
                free_head_reg <= link_rd_reg.slot;
                free_ne_reg   <= link_rd_reg.valid;
                if (!nonempty_reg[q_reg])
                begin
                    head_reg[q_reg]     <= idx_reg;
                    nonempty_reg[q_reg] <= 1'b1;
                end
                tail_reg[q_reg] <= idx_reg;
            end
            else
            begin
                head_reg[q_reg]     <= link_rd_reg.slot;
                nonempty_reg[q_reg] <= link_rd_reg.valid;
                free_head_reg       <= idx_reg;
                free_ne_reg         <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= res_reg;
            if ((op_reg == OP_POP) && (res_reg == ST_OK))
            begin
                pop_data_reg <= WORD_W'(data_rd_reg);
            end
            else
            begin
                pop_data_reg <= '0;
            end
        end
    end

    assign pop_data = $signed(pop_data_reg);
    assign status   = status_reg;

endmodule

[src/shared_buffer_multi_queue.sv]
// flow: execute reads the link store, write-back writes links and pointers and
// registers the result, waiting while an earlier result is still held; a new
// item is taken only in idle or at that write-back's commit
// reset: asynchronous, free list in slot order and all queues empty at once,
// per-slot link valid bits stand in for a clearing pass
module shared_buffer_multi_queue
    import sbmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sbmq_req_if.sink   req,
    sbmq_rsp_if.source rsp
);

    sbmq_cmd_t cmd;

    sbmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sbmq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .opcode    (req.opcode),
        .queue_id  (req.queue_id),
        .push_data (req.push_data),
        .pop_data  (rsp.pop_data),
        .status    (rsp.status)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import sbmq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 132;
    localparam int PLAN_ROWS      = 25;

    typedef struct {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
    } reply_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [QID_W-1:0]    qid;
        logic [WORD_W-1:0]   word;
        bit                  known;
        logic [WORD_W-1:0]   exp_word;
        logic [STATUS_W-1:0] exp_status;
    } plan_row_t;

    logic clk;
    logic rst_n;

    sbmq_req_if req ();
    sbmq_rsp_if rsp ();

    shared_buffer_multi_queue dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // shadow copy of the slot pool
    logic [SLOT_W-1:0] head_of [QUEUES];
    logic [SLOT_W-1:0] tail_of [QUEUES];
    bit                holds_items [QUEUES];
    link_t             next_of [SLOTS];
    logic [WORD_W-1:0] word_of [SLOTS];
    logic [SLOT_W-1:0] free_top;
    bit                free_any;

    reply_t due_replies [$];

    int  errors;
    int  n_items;
    int  n_push;
    int  n_pop;
    int  n_over;
    int  n_under;
    int  idle_pct;
    int  stall_pct;
    int  quiet_cycles;
    int  hold_requests;

    // pops ignore push_data, so some pop rows carry nonzero words
    plan_row_t plan [PLAN_ROWS] = '{
        '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_PUSH, 2'd0, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd1, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{OP_POP,  2'd1, 32'h1357_9bdf, 1'b1, 32'h8000_0000, ST_OK},
        '{OP_POP,  2'd1, 32'hffff_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
        '{OP_PUSH, 2'd1, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
        '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK},
        '{OP_PUSH, 2'd2, 32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd3, 32'haaaa_aaaa, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd0, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd1, 32'hdead_beef, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd2, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd3, 32'h8000_0001, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd0, 32'h0f0f_0f0f, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd1, 32'hf0f0_f0f0, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd2, 32'h1234_5678, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd3, 32'h8765_4321, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd0, 32'h00ff_00ff, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd1, 32'hff00_ff00, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd2, 32'h7fff_fffe, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd3, 32'hffff_fffe, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd2, 32'h0000_8000, 1'b0, 32'h0000_0000, ST_OK},
        '{OP_PUSH, 2'd3, 32'hcafe_f00d, 1'b1, 32'h0000_0000, ST_OVERFLOW},
        '{OP_POP,  2'd1, 32'hffff_ffff, 1'b1, 32'hffff_ffff, ST_OK},
        '{OP_PUSH, 2'd2, 32'h0123_4567, 1'b0, 32'h0000_0000, ST_OK}
    };

    always #6 clk = ~clk;

    function automatic reply_t apply_pool_op(logic [OPCODE_W-1:0] op,
                                             logic [QID_W-1:0] qid,
                                             logic [WORD_W-1:0] word);
        reply_t            r;
        int                q;
        logic [SLOT_W-1:0] s;
        q = int'(qid) % QUEUES;
        r.word = '0;
        r.status = ST_OK;
        if (op == OP_PUSH)
        begin
            if (!free_any)
            begin
                r.status = ST_OVERFLOW;
                n_over++;
            end
            else
            begin
                s = free_top;
                free_top = next_of[s].slot;
                free_any = next_of[s].valid;
                if (!holds_items[q])
                begin
                    head_of[q] = s;
                    holds_items[q] = 1'b1;
                end
                else
                begin
                    next_of[tail_of[q]] = '{valid: 1'b1, slot: s};
                end
                next_of[s] = '{valid: 1'b0, slot: '0};
                tail_of[q] = s;
                word_of[s] = word;
                n_push++;
            end
        end
        else
        begin
            if (!holds_items[q])
            begin
                r.status = ST_UNDERFLOW;
                n_under++;
            end
            else
            begin
                s = head_of[q];
                head_of[q] = next_of[s].slot;
                holds_items[q] = next_of[s].valid;
                next_of[s] = '{valid: free_any, slot: free_top};
                free_top = s;
                free_any = 1'b1;
                r.word = word_of[s];
                n_pop++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_op(logic [OPCODE_W-1:0] op, logic [QID_W-1:0] qid,
                           logic [WORD_W-1:0] word, bit known, reply_t known_reply);
        reply_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.queue_id <= qid;
        req.push_data <= word;
        do
            @(posedge clk);
        while (!req.ready);
        r = apply_pool_op(op, qid, word);
        due_replies.push_back(known ? known_reply : r);
        n_items++;
    endtask

    task automatic drain_replies();
        req.valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result checker and watchdog
    initial
    begin
        reply_t want;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                    quiet_cycles = 0;
                else
                    quiet_cycles++;
                if (rsp.valid && rsp.ready)
                begin
                    if (due_replies.size() == 0)
                    begin
                        report_mismatch("unexpected item, pop_data", rsp.pop_data, '0);
                    end
                    else
                    begin
                        want = due_replies.pop_front();
                        if (rsp.pop_data !== want.word)
                            report_mismatch("pop_data", rsp.pop_data, want.word);
                        if (rsp.status !== want.status)
                            report_mismatch("status", WORD_W'(rsp.status), WORD_W'(want.status));
                    end
                end
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                    $display("shared_buffer_multi_queue test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        reply_t            no_reply;
        reply_t            row_reply;
        logic [OPCODE_W-1:0] op;
        logic [QID_W-1:0]  qid;
        logic [WORD_W-1:0] word;
        int                bias;
        int                sent;
        int                pick;
        int                burst;

        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = OP_PUSH;
        req.queue_id = '0;
        req.push_data = '0;
        hold_requests = 0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        n_items = 0;
        n_push = 0;
        n_pop = 0;
        n_over = 0;
        n_under = 0;
        no_reply.word = '0;
        no_reply.status = ST_OK;

        for (int i = 0; i < QUEUES; i++)
        begin
            head_of[i] = '0;
            tail_of[i] = '0;
            holds_items[i] = 1'b0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            next_of[i].valid = (i < SLOTS - 1);
            next_of[i].slot = SLOT_W'((i + 1) % SLOTS);
            word_of[i] = '0;
        end
        free_top = '0;
        free_any = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row_reply.word = plan[i].exp_word;
            row_reply.status = plan[i].exp_status;
            send_op(plan[i].op, plan[i].qid, plan[i].word, plan[i].known, row_reply);
        end
        drain_replies();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_requests++;
                end
                1:
                begin
                    idle_pct = 58;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 58;
                end
                default:
                begin
                    idle_pct = 35;
                    stall_pct <= 35;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // bursts that lean toward filling, draining or churning the pool
                case ($urandom_range(2))
                    0: bias = 80;
                    1: bias = 20;
                    default: bias = 50;
                endcase
                burst = $urandom_range(6, 24);
                if (burst > PHASE_ITEMS - sent)
                    burst = PHASE_ITEMS - sent;
                repeat (burst)
                begin
                    op = ($urandom_range(99) < bias) ? OP_PUSH : OP_POP;
                    qid = QID_W'($urandom_range(QUEUES - 1));
                    if (op == OP_POP && $urandom_range(99) < 85)
                    begin
                        for (int k = 0; k < QUEUES; k++)
                        begin
                            pick = (int'(qid) + k) % QUEUES;
                            if (holds_items[pick])
                            begin
                                qid = QID_W'(pick);
                                break;
                            end
                        end
                    end
                    case ($urandom_range(9))
                        0: word = 32'h7fff_ffff;
                        1: word = 32'h8000_0000;
                        2: word = ($urandom_range(1) == 0) ? 32'h0 : 32'hffff_ffff;
                        default: word = $urandom();
                    endcase
                    send_op(op, qid, word, 1'b0, no_reply);
                    sent++;
                end
            end
            drain_replies();
        end

        repeat (20) @(posedge clk);

        $display("ran %0d items: directed table, then random bursts under four idle/stall mixes",
                 n_items);
        $display("pushes %0d, pops %0d, overflows %0d, underflows %0d",
                 n_push, n_pop, n_over, n_under);
        if (errors == 0)
            $display("shared_buffer_multi_queue test passed");
        else
            $display("shared_buffer_multi_queue test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/sbmq_pkg.sv
src/sbmq_req_if.sv
src/sbmq_rsp_if.sv
src/sbmq_ctrl.sv
src/sbmq_dp.sv
src/shared_buffer_multi_queue.sv
dv/tb.sv
